// ----- design/owm_pkg.sv -----
// ----------------------------------------------------------------------------
// owm_pkg - shared types and constants of the 1-Wire slot engine
// Item formats, configuration register map and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

  // Tick counter width; the counter saturates at its all-ones value.
  localparam int unsigned TickCountWidth = 10;
  localparam int unsigned CfgWidth       = 10;
  localparam int unsigned NumCfg         = 7;
  localparam int unsigned CfgIdxWidth    = $clog2(NumCfg);
  localparam int unsigned CmpWidth       =
      (TickCountWidth > CfgWidth) ? TickCountWidth : CfgWidth;

  localparam logic [TickCountWidth-1:0] CntMax = '1;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CFG_RESET_LOW       = CfgIdxWidth'(0);
  localparam logic [CfgIdxWidth-1:0] CFG_PRESENCE_SAMPLE = CfgIdxWidth'(1);
  localparam logic [CfgIdxWidth-1:0] CFG_RESET_TAIL      = CfgIdxWidth'(2);
  localparam logic [CfgIdxWidth-1:0] CFG_ZERO_LOW        = CfgIdxWidth'(3);
  localparam logic [CfgIdxWidth-1:0] CFG_SHORT_LOW       = CfgIdxWidth'(4);
  localparam logic [CfgIdxWidth-1:0] CFG_READ_SAMPLE     = CfgIdxWidth'(5);
  localparam logic [CfgIdxWidth-1:0] CFG_SLOT_TOTAL      = CfgIdxWidth'(6);

  localparam logic [CfgWidth-1:0] RstResetLow       = CfgWidth'(480);
  localparam logic [CfgWidth-1:0] RstPresenceSample = CfgWidth'(70);
  localparam logic [CfgWidth-1:0] RstResetTail      = CfgWidth'(410);
  localparam logic [CfgWidth-1:0] RstZeroLow        = CfgWidth'(60);
  localparam logic [CfgWidth-1:0] RstShortLow       = CfgWidth'(6);
  localparam logic [CfgWidth-1:0] RstReadSample     = CfgWidth'(9);
  localparam logic [CfgWidth-1:0] RstSlotTotal      = CfgWidth'(70);

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_RESET = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] write_data;
    logic       bus_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       presence;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [CfgWidth-1:0] reset_low;
    logic [CfgWidth-1:0] presence_sample;
    logic [CfgWidth-1:0] reset_tail;
    logic [CfgWidth-1:0] zero_low;
    logic [CfgWidth-1:0] short_low;
    logic [CfgWidth-1:0] read_sample;
    logic [CfgWidth-1:0] slot_total;
  } cfg_t;

  // Count has reached a threshold; thresholds above the counter range clamp.
  function automatic logic cnt_reached(logic [TickCountWidth-1:0] cnt,
                                       logic [CfgWidth-1:0] thr);
    logic [CmpWidth-1:0] c;
    logic [CmpWidth-1:0] t;
    logic [CmpWidth-1:0] m;
    c = CmpWidth'(cnt);
    t = CmpWidth'(thr);
    m = CmpWidth'(CntMax);
    if (t > m) begin
      t = m;
    end
    return c >= t;
  endfunction

endpackage

`default_nettype wire

// ----- design/owm_in_if.sv -----
// ----------------------------------------------------------------------------
// owm_in_if - command/tick item channel
// Valid/ready channel carrying one input item.
// ----------------------------------------------------------------------------
`default_nettype none

interface owm_in_if;
  logic              valid;
  logic              ready;
  owm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/owm_out_if.sv -----
// ----------------------------------------------------------------------------
// owm_out_if - result item channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface owm_out_if;
  logic               valid;
  logic               ready;
  owm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/owm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// owm_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface owm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [owm_pkg::CfgIdxWidth-1:0]    index;
  logic [owm_pkg::CfgWidth-1:0]       wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- design/owm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// owm_cfg_regs - timing configuration registers
// Seven 10-bit timing registers, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_cfg_regs (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  owm_cfg_if.sink        cfg_i,
  output owm_pkg::cfg_t  cfg_o
);

  owm_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        owm_pkg::CFG_RESET_LOW:       cfg_d.reset_low       = cfg_i.wdata;
        owm_pkg::CFG_PRESENCE_SAMPLE: cfg_d.presence_sample = cfg_i.wdata;
        owm_pkg::CFG_RESET_TAIL:      cfg_d.reset_tail      = cfg_i.wdata;
        owm_pkg::CFG_ZERO_LOW:        cfg_d.zero_low        = cfg_i.wdata;
        owm_pkg::CFG_SHORT_LOW:       cfg_d.short_low       = cfg_i.wdata;
        owm_pkg::CFG_READ_SAMPLE:     cfg_d.read_sample     = cfg_i.wdata;
        owm_pkg::CFG_SLOT_TOTAL:      cfg_d.slot_total      = cfg_i.wdata;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low       <= owm_pkg::RstResetLow;
      cfg_q.presence_sample <= owm_pkg::RstPresenceSample;
      cfg_q.reset_tail      <= owm_pkg::RstResetTail;
      cfg_q.zero_low        <= owm_pkg::RstZeroLow;
      cfg_q.short_low       <= owm_pkg::RstShortLow;
      cfg_q.read_sample     <= owm_pkg::RstReadSample;
      cfg_q.slot_total      <= owm_pkg::RstSlotTotal;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- design/owm_slot_fsm.sv -----
// ----------------------------------------------------------------------------
// owm_slot_fsm - 1-Wire phase machine
// Advances reset and bit-slot phases by one item and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_slot_fsm (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire owm_pkg::in_item_t  item_i,
  input  wire owm_pkg::cfg_t      cfg_i,
  output owm_pkg::out_item_t      res_o
);

  typedef enum logic [6:0] {
    PH_IDLE        = 7'b0000001,
    PH_RST_LOW     = 7'b0000010,
    PH_RST_WAIT    = 7'b0000100,
    PH_RST_TAIL    = 7'b0001000,
    PH_SLOT_LOW    = 7'b0010000,
    PH_SLOT_SAMPLE = 7'b0100000,
    PH_SLOT_REST   = 7'b1000000
  } phase_e;

  localparam int unsigned CW = owm_pkg::CfgWidth;
  localparam int unsigned TW = owm_pkg::TickCountWidth;

  phase_e             phase_q, phase_d;
  logic [TW-1:0]      tick_q, tick_d, tick_inc;
  logic [2:0]         bit_q, bit_d;
  logic [7:0]         shift_q, shift_d;
  owm_pkg::kind_e     op_q, op_d;
  logic               pres_q, pres_d;
  logic [7:0]         rdata_q, rdata_d;
  logic               done, rej;

  logic [CW-1:0]      low_len;
  logic [CW:0]        spent;
  logic [CW-1:0]      rest;

  assign tick_inc = (tick_q < owm_pkg::CntMax) ? tick_q + 1'b1 : tick_q;

  // Low pulse: long only for a zero bit of a write.
  assign low_len = (op_q == owm_pkg::KIND_WRITE && !shift_q[bit_q]) ?
                   cfg_i.zero_low : cfg_i.short_low;
  assign spent   = (op_q == owm_pkg::KIND_READ) ?
                   {1'b0, cfg_i.short_low} + {1'b0, cfg_i.read_sample} :
                   {1'b0, low_len};
  assign rest    = ({1'b0, cfg_i.slot_total} > spent) ?
                   CW'({1'b0, cfg_i.slot_total} - spent) : '0;

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    op_d    = op_q;
    pres_d  = pres_q;
    rdata_d = rdata_q;
    done    = 1'b0;
    rej     = 1'b0;
    if (step_i) begin
      if (item_i.kind != owm_pkg::KIND_TICK) begin
        if (phase_q != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          op_d   = item_i.kind;
          tick_d = '0;
          bit_d  = '0;
          if (item_i.kind == owm_pkg::KIND_RESET) begin
            pres_d  = 1'b0;
            phase_d = PH_RST_LOW;
          end else begin
            shift_d = (item_i.kind == owm_pkg::KIND_WRITE) ? item_i.write_data : 8'h00;
            phase_d = PH_SLOT_LOW;
          end
        end
      end else if (phase_q != PH_IDLE) begin
        tick_d = tick_inc;
        unique case (phase_q)
          PH_RST_LOW: begin
            if (owm_pkg::cnt_reached(tick_inc, cfg_i.reset_low)) begin
              tick_d  = '0;
              phase_d = PH_RST_WAIT;
            end
          end
          PH_RST_WAIT: begin
            if (owm_pkg::cnt_reached(tick_inc, cfg_i.presence_sample)) begin
              pres_d  = ~item_i.bus_level;
              tick_d  = '0;
              phase_d = PH_RST_TAIL;
            end
          end
          PH_RST_TAIL: begin
            if (owm_pkg::cnt_reached(tick_inc, cfg_i.reset_tail)) begin
              tick_d  = '0;
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end
          PH_SLOT_LOW: begin
            if (owm_pkg::cnt_reached(tick_inc, low_len)) begin
              tick_d  = '0;
              phase_d = (op_q == owm_pkg::KIND_READ) ? PH_SLOT_SAMPLE : PH_SLOT_REST;
            end
          end
          PH_SLOT_SAMPLE: begin
            if (owm_pkg::cnt_reached(tick_inc, cfg_i.read_sample)) begin
              if (item_i.bus_level) begin
                shift_d[bit_q] = 1'b1;
              end
              tick_d  = '0;
              phase_d = PH_SLOT_REST;
            end
          end
          PH_SLOT_REST: begin
            if (owm_pkg::cnt_reached(tick_inc, rest)) begin
              tick_d = '0;
              if (bit_q == 3'd7) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
                if (op_q == owm_pkg::KIND_READ) begin
                  rdata_d = shift_q;
                end
              end else begin
                bit_d   = bit_q + 3'd1;
                phase_d = PH_SLOT_LOW;
              end
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      op_q    <= owm_pkg::KIND_TICK;
      pres_q  <= 1'b0;
      rdata_q <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      op_q    <= op_d;
      pres_q  <= pres_d;
      rdata_q <= rdata_d;
    end
  end

  // Result reflects the state after this item.
  assign res_o.drive_low = (phase_d == PH_RST_LOW) || (phase_d == PH_SLOT_LOW);
  assign res_o.busy_res  = (phase_d != PH_IDLE);
  assign res_o.done_res  = done;
  assign res_o.read_data = rdata_d;
  assign res_o.presence  = pres_d;
  assign res_o.rejected  = rej;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |-> !res_o.busy_res && !res_o.drive_low)
    else $error("done reported while still busy");

  a_rej_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.rejected |=> $stable(phase_q) && $stable(tick_q) && $stable(bit_q))
    else $error("rejected command changed the phase state");

  a_idle_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> tick_q == '0 && !(step_i && res_o.done_res))
    else $error("idle with running counter or spurious done");

endmodule

`default_nettype wire

// ----- design/one_wire_master_slot_engine.sv -----
// ----------------------------------------------------------------------------
// one_wire_master_slot_engine - 1-Wire bus master driven by tick items
// Input register, phase machine, result register; config registers aside.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                           handshake
//  in_i     in   kind, write_data, bus_level                       valid/ready
//  out_o    out  drive_low, busy_res, done_res, read_data,
//                presence, rejected                                valid/ready
//  cfg_i    in   index (3b), wdata (10b)                           valid/ready
//
//  One item per cycle sustained while results are taken; an accepted item
//  passes the input register, then the phase logic into the result register,
//  where its result is valid until it is taken.
//  The phase machine steps when the input register moves into the result
//  register; a stalled result stops both stages, nothing is dropped.
//  Reset clears the valid flags and phase state and loads the default timings; cfg_i is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_master_slot_engine (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  owm_in_if.sink    in_i,
  owm_out_if.source out_o,
  owm_cfg_if.sink   cfg_i
);

  owm_pkg::cfg_t      cfg;
  owm_pkg::in_item_t  s1_item_q;
  logic               s1_valid_q;
  owm_pkg::out_item_t res;
  owm_pkg::out_item_t out_item_q;
  logic               out_valid_q;
  logic               advance;
  logic               step;

  assign advance    = !out_valid_q || out_o.ready;
  assign step       = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;

  owm_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  owm_slot_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= in_i.data;
    end
    if (step) begin
      out_item_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_item_q))
    else $error("input stage lost an item under stall");

endmodule

`default_nettype wire

// ----- tb/owm_slot_checker.sv -----
// ----------------------------------------------------------------------------
// owm_slot_checker - result predictor and comparator for the 1-Wire slot engine
// Watches the item, result and config channels, keeps its own copy of the
// phase machine and timings, and compares every result field by field.
// ----------------------------------------------------------------------------
module owm_slot_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  owm_pkg::in_item_t               in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  owm_pkg::out_item_t              out_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [owm_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [owm_pkg::CfgWidth-1:0]    cfg_wdata_i,
  output int                              pending_o,
  output logic                            busy_o,
  output int                              errors_o
);

  typedef enum logic [2:0] {
    LINE_IDLE,
    LINE_RST_LOW,
    LINE_RST_WAIT,
    LINE_RST_TAIL,
    LINE_SLOT_LOW,
    LINE_SLOT_SAMPLE,
    LINE_SLOT_REST
  } line_phase_e;

  line_phase_e                        phase_q;
  logic [owm_pkg::TickCountWidth-1:0] ticks_q;
  logic [2:0]                         bit_q;
  logic [7:0]                         shift_q;
  logic [7:0]                         read_byte_q;
  owm_pkg::kind_e                     op_q;
  logic                               present_q;
  logic [owm_pkg::CfgWidth-1:0]       timing_q [owm_pkg::NumCfg];

  owm_pkg::out_item_t bus_results_q [$];
  int                 mismatch_count = 0;
  int                 result_no = 0;

  assign errors_o = mismatch_count;

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    mismatch_count++;
    $display("MISMATCH at result %0d: %s got %0h want %0h", result_no, what, got, want);
  endtask

  // thresholds beyond the counter range are clamped to its top
  function automatic bit count_hit(int thr);
    int lim;
    lim = thr;
    if (lim > int'(owm_pkg::CntMax)) begin
      lim = int'(owm_pkg::CntMax);
    end
    return int'(ticks_q) >= lim;
  endfunction

  function automatic int low_ticks();
    if (op_q == owm_pkg::KIND_WRITE && !shift_q[bit_q]) begin
      return int'(timing_q[owm_pkg::CFG_ZERO_LOW]);
    end
    return int'(timing_q[owm_pkg::CFG_SHORT_LOW]);
  endfunction

  function automatic owm_pkg::out_item_t step_slot_engine(owm_pkg::in_item_t it);
    owm_pkg::out_item_t res;
    logic               done;
    logic               rej;
    int                 spent;
    int                 rest;
    done = 1'b0;
    rej  = 1'b0;
    if (it.kind != owm_pkg::KIND_TICK) begin
      if (phase_q != LINE_IDLE) begin
        rej = 1'b1;
      end else begin
        op_q    = it.kind;
        ticks_q = '0;
        bit_q   = '0;
        if (it.kind == owm_pkg::KIND_RESET) begin
          present_q = 1'b0;
          phase_q   = LINE_RST_LOW;
        end else begin
          shift_q = (it.kind == owm_pkg::KIND_WRITE) ? it.write_data : 8'h00;
          phase_q = LINE_SLOT_LOW;
        end
      end
    end else if (phase_q != LINE_IDLE) begin
      if (ticks_q != owm_pkg::CntMax) begin
        ticks_q++;
      end
      case (phase_q)
        LINE_RST_LOW: begin
          if (count_hit(int'(timing_q[owm_pkg::CFG_RESET_LOW]))) begin
            ticks_q = '0;
            phase_q = LINE_RST_WAIT;
          end
        end
        LINE_RST_WAIT: begin
          if (count_hit(int'(timing_q[owm_pkg::CFG_PRESENCE_SAMPLE]))) begin
            present_q = ~it.bus_level;
            ticks_q   = '0;
            phase_q   = LINE_RST_TAIL;
          end
        end
        LINE_RST_TAIL: begin
          if (count_hit(int'(timing_q[owm_pkg::CFG_RESET_TAIL]))) begin
            ticks_q = '0;
            phase_q = LINE_IDLE;
            done    = 1'b1;
          end
        end
        LINE_SLOT_LOW: begin
          if (count_hit(low_ticks())) begin
            ticks_q = '0;
            phase_q = (op_q == owm_pkg::KIND_READ) ? LINE_SLOT_SAMPLE : LINE_SLOT_REST;
          end
        end
        LINE_SLOT_SAMPLE: begin
          if (count_hit(int'(timing_q[owm_pkg::CFG_READ_SAMPLE]))) begin
            if (it.bus_level) begin
              shift_q[bit_q] = 1'b1;
            end
            ticks_q = '0;
            phase_q = LINE_SLOT_REST;
          end
        end
        LINE_SLOT_REST: begin
          // rest of the slot; a non-positive remainder still costs one tick
          spent = (op_q == owm_pkg::KIND_READ) ?
                  int'(timing_q[owm_pkg::CFG_SHORT_LOW]) +
                  int'(timing_q[owm_pkg::CFG_READ_SAMPLE]) :
                  low_ticks();
          rest  = (int'(timing_q[owm_pkg::CFG_SLOT_TOTAL]) > spent) ?
                  int'(timing_q[owm_pkg::CFG_SLOT_TOTAL]) - spent : 0;
          if (count_hit(rest)) begin
            ticks_q = '0;
            if (bit_q == 3'd7) begin
              phase_q = LINE_IDLE;
              done    = 1'b1;
              if (op_q == owm_pkg::KIND_READ) begin
                read_byte_q = shift_q;
              end
            end else begin
              bit_q++;
              phase_q = LINE_SLOT_LOW;
            end
          end
        end
        default: ;
      endcase
    end
    res.drive_low = (phase_q == LINE_RST_LOW || phase_q == LINE_SLOT_LOW);
    res.busy_res  = (phase_q != LINE_IDLE);
    res.done_res  = done;
    res.read_data = read_byte_q;
    res.presence  = present_q;
    res.rejected  = rej;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    owm_pkg::out_item_t want;
    if (!rst_ni) begin
      phase_q     = LINE_IDLE;
      ticks_q     = '0;
      bit_q       = '0;
      shift_q     = '0;
      read_byte_q = '0;
      op_q        = owm_pkg::KIND_TICK;
      present_q   = 1'b0;
      timing_q[owm_pkg::CFG_RESET_LOW]       = owm_pkg::RstResetLow;
      timing_q[owm_pkg::CFG_PRESENCE_SAMPLE] = owm_pkg::RstPresenceSample;
      timing_q[owm_pkg::CFG_RESET_TAIL]      = owm_pkg::RstResetTail;
      timing_q[owm_pkg::CFG_ZERO_LOW]        = owm_pkg::RstZeroLow;
      timing_q[owm_pkg::CFG_SHORT_LOW]       = owm_pkg::RstShortLow;
      timing_q[owm_pkg::CFG_READ_SAMPLE]     = owm_pkg::RstReadSample;
      timing_q[owm_pkg::CFG_SLOT_TOTAL]      = owm_pkg::RstSlotTotal;
      bus_results_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (bus_results_q.size() == 0) begin
          report_mismatch("result with nothing pending", '0, '0);
        end else begin
          want = bus_results_q.pop_front();
          if (out_data_i.drive_low !== want.drive_low)
            report_mismatch("drive_low", out_data_i.drive_low, want.drive_low);
          if (out_data_i.busy_res !== want.busy_res)
            report_mismatch("busy_res", out_data_i.busy_res, want.busy_res);
          if (out_data_i.done_res !== want.done_res)
            report_mismatch("done_res", out_data_i.done_res, want.done_res);
          if (out_data_i.read_data !== want.read_data)
            report_mismatch("read_data", out_data_i.read_data, want.read_data);
          if (out_data_i.presence !== want.presence)
            report_mismatch("presence", out_data_i.presence, want.presence);
          if (out_data_i.rejected !== want.rejected)
            report_mismatch("rejected", out_data_i.rejected, want.rejected);
        end
        result_no++;
      end
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < owm_pkg::NumCfg) begin
        timing_q[cfg_index_i] = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        bus_results_q.push_back(step_slot_engine(in_data_i));
      end
    end
    pending_o <= bus_results_q.size();
    busy_o    <= (phase_q != LINE_IDLE);
  end

endmodule

// ----- tb/tb_one_wire_master_slot_engine.sv -----
// ----------------------------------------------------------------------------
// tb_one_wire_master_slot_engine - testbench top of the 1-Wire slot engine
// Drives reset, write and read commands with tick items under several timing
// sets (defaults, short, all-min, random small), with random idling on both
// channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_one_wire_master_slot_engine;

  localparam int RandomItems  = 100;
  localparam int DefaultTicks = 75;
  localparam int CycleLimit   = 2_000_000;
  localparam int DrainCycles  = 10;

  // bus level pattern during an operation
  localparam int BusLow    = 0;
  localparam int BusHigh   = 1;
  localparam int BusRandom = 2;

  localparam logic [owm_pkg::CfgIdxWidth-1:0] RegOrder [owm_pkg::NumCfg] = '{
    owm_pkg::CFG_RESET_LOW, owm_pkg::CFG_PRESENCE_SAMPLE, owm_pkg::CFG_RESET_TAIL,
    owm_pkg::CFG_ZERO_LOW, owm_pkg::CFG_SHORT_LOW, owm_pkg::CFG_READ_SAMPLE,
    owm_pkg::CFG_SLOT_TOTAL
  };

  logic clk_i;
  logic rst_ni;
  int   pending;
  logic busy;
  int   errors;
  int   item_count = 0;
  bit   in_idle_on = 1'b1;
  bit   out_idle_on = 1'b1;

  logic [owm_pkg::CfgWidth-1:0] next_timing [owm_pkg::NumCfg];

  owm_in_if  in_ch ();
  owm_out_if out_ch ();
  owm_cfg_if cfg_ch ();

  one_wire_master_slot_engine u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  owm_slot_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_data_i   (in_ch.data),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_i  (out_ch.data),
    .cfg_valid_i (cfg_ch.valid),
    .cfg_ready_i (cfg_ch.ready),
    .cfg_index_i (cfg_ch.index),
    .cfg_wdata_i (cfg_ch.wdata),
    .pending_o   (pending),
    .busy_o      (busy),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("** one_wire_master_slot_engine: FAILED **");
    $finish;
  end

  // result side: random stalls with stretches of none
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) out_idle_on = !out_idle_on;
      stall = out_idle_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  function automatic logic line_level(int mode);
    if (mode == BusLow) return 1'b0;
    if (mode == BusHigh) return 1'b1;
    return 1'($urandom);
  endfunction

  task automatic push_item(owm_pkg::kind_e k, logic [7:0] d, logic b);
    int gap;
    if ($urandom_range(0, 39) == 0) in_idle_on = !in_idle_on;
    gap = in_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.data.kind       <= k;
    in_ch.data.write_data <= d;
    in_ch.data.bus_level  <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    item_count++;
  endtask

  task automatic run_ticks(int n, int bus_mode);
    repeat (n) push_item(owm_pkg::KIND_TICK, 8'($urandom), line_level(bus_mode));
  endtask

  // Start a command, then tick until it is over. busy lags one item, so the
  // loop only ends after a tick that followed an idle state.
  task automatic run_op(owm_pkg::kind_e k, logic [7:0] d, int bus_mode, int noise_pct);
    bit last_cmd;
    push_item(k, d, line_level(bus_mode));
    last_cmd = 1'b1;
    while (busy || last_cmd) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        push_item(owm_pkg::kind_e'($urandom_range(1, 3)), 8'($urandom),
                  line_level(bus_mode));
        last_cmd = 1'b1;
      end else begin
        push_item(owm_pkg::KIND_TICK, 8'($urandom), line_level(bus_mode));
        last_cmd = 1'b0;
      end
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_timings();
    drain();
    for (int i = 0; i < owm_pkg::NumCfg; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= RegOrder[i];
      cfg_ch.wdata <= next_timing[i];
      do @(posedge clk_i); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_mixed_ops(int n, int noise_pct);
    repeat (n) begin
      run_op(owm_pkg::kind_e'($urandom_range(1, 3)), 8'($urandom), BusRandom, noise_pct);
    end
  endtask

  initial begin
    int start_items;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.wdata <= '0;
    rst_ni       <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timings: first slot of a read, then a command while busy
    push_item(owm_pkg::KIND_TICK, 8'h00, 1'b0);
    push_item(owm_pkg::KIND_READ, 8'h00, 1'b1);
    run_ticks(DefaultTicks, BusRandom);
    push_item(owm_pkg::KIND_WRITE, 8'h3C, 1'b0);

    // short timings; read and zero-write slots overrun slot_total
    next_timing = '{10'd3, 10'd2, 10'd2, 10'd5, 10'd2, 10'd3, 10'd4};
    load_timings();
    // finish the read that is still running
    run_op(owm_pkg::KIND_TICK, 8'h00, BusRandom, 0);
    push_item(owm_pkg::KIND_TICK, 8'hFF, 1'b1);
    push_item(owm_pkg::KIND_TICK, 8'h00, 1'b0);
    run_op(owm_pkg::KIND_RESET, 8'h00, BusLow, 0);
    run_op(owm_pkg::KIND_RESET, 8'hFF, BusHigh, 0);
    run_op(owm_pkg::KIND_WRITE, 8'hFF, BusLow, 0);
    run_op(owm_pkg::KIND_WRITE, 8'hA5, BusRandom, 40);
    run_op(owm_pkg::KIND_READ, 8'h00, BusLow, 0);
    run_op(owm_pkg::KIND_READ, 8'h5A, BusRandom, 40);
    run_op(owm_pkg::KIND_RESET, 8'h00, BusRandom, 40);

    // everything at its minimum
    next_timing = '{default: owm_pkg::CfgWidth'(1)};
    load_timings();
    run_op(owm_pkg::KIND_RESET, 8'h00, BusRandom, 20);
    run_op(owm_pkg::KIND_WRITE, 8'($urandom), BusRandom, 20);
    run_op(owm_pkg::KIND_READ, 8'h00, BusRandom, 20);

    // random small timing sets, zero included
    start_items = item_count;
    while (item_count - start_items < RandomItems) begin
      for (int i = 0; i < owm_pkg::NumCfg; i++) begin
        next_timing[i] = ($urandom_range(0, 7) == 0) ?
                         owm_pkg::CfgWidth'($urandom_range(7, 24)) :
                         owm_pkg::CfgWidth'($urandom_range(0, 4));
      end
      load_timings();
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 4) == 0) begin
          push_item(owm_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
        end
        run_mixed_ops(1, 6);
      end
    end

    drain();
    if (errors == 0) begin
      $display("** one_wire_master_slot_engine: PASSED **");
    end else begin
      $display("** one_wire_master_slot_engine: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/owm_pkg.sv
design/owm_in_if.sv
design/owm_out_if.sv
design/owm_cfg_if.sv
design/owm_cfg_regs.sv
design/owm_slot_fsm.sv
design/one_wire_master_slot_engine.sv
tb/owm_slot_checker.sv
tb/tb_one_wire_master_slot_engine.sv
